// File: rtl/spc_pkg.sv
// Shared constants for the synchronizing pair check.
// No dependencies.
package spc_pkg;
  localparam int MAX_STATES_DEF  = 16;
  localparam int MAX_LETTERS_DEF = 4;
  localparam int TW              = 4;  // table entry (state) width
  localparam int SCW             = 5;  // state_count register width
  localparam int LCW             = 3;  // letter_count register width
  localparam int SC_RST          = 16;
  localparam int LC_RST          = 2;
  localparam logic CFG_STATE_COUNT  = 1'b0;
  localparam logic CFG_LETTER_COUNT = 1'b1;
endpackage

// File: rtl/spc_table.sv
// Transition table memory: one write port, two registered read ports.
// Depends on spc_pkg.
module spc_table
  import spc_pkg::*;
#(
  parameter int DEPTH = MAX_STATES_DEF * MAX_LETTERS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [TW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [TW-1:0] rdata_a,
  output logic [TW-1:0] rdata_b
);
  logic [TW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// File: rtl/spc_pair.sv
// Pair-mergeable bit memory: one write port, one registered read port.
// Depends on spc_pkg.
module spc_pair
  import spc_pkg::*;
#(
  parameter int DEPTH = MAX_STATES_DEF * MAX_STATES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/synchronizing_pair_check.sv
// Synchronizing-automaton check by pair-graph fixed point.
// Depends on spc_pkg, spc_table, spc_pair.
//
// Table entries (from_state, letter, next_state) load one per cycle into a
// transition memory; entries outside the table are dropped. A transaction
// with last set writes its entry and then starts the check; input stalls
// until the check ends. The check first clears the pair memory, one pair in
// use at a time, then sweeps all pairs until a sweep changes nothing. Per
// pair: ST_PM reads the pair bit and the letter-0 targets; ST_CHK skips a
// pair already merged, else evaluates the letter. A target pair that must be
// looked up in the pair memory is read out in ST_LOOK, and the next letter's
// targets are fetched in ST_TRD and evaluated in ST_TEV. The result sits in
// an output register; one more result is not produced until the previous one
// has been taken.
module synchronizing_pair_check
  import spc_pkg::*;
#(
  parameter int MAX_STATES  = MAX_STATES_DEF,
  parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_from_state,
  input  logic [1:0] in_letter,
  input  logic [3:0] in_next_state,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_synchronizing,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);
  localparam int TDEPTH = MAX_STATES * MAX_LETTERS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int PDEPTH = MAX_STATES * MAX_STATES;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int SW     = $clog2(MAX_STATES);
  localparam int CW     = $clog2(MAX_STATES + 1);
  localparam int LW     = $clog2(MAX_LETTERS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_PM   = 3'd2;  // issue pair bit + letter 0 reads
  localparam logic [2:0] ST_CHK  = 3'd3;  // skip test + evaluate letter
  localparam logic [2:0] ST_TRD  = 3'd4;  // issue next letter reads
  localparam logic [2:0] ST_TEV  = 3'd5;  // evaluate letter
  localparam logic [2:0] ST_LOOK = 3'd6;  // target pair bit available
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [SCW-1:0] sc_r;
  logic [LCW-1:0] lc_r;
  logic [2:0]     st_r, st_nxt;
  logic [SW-1:0]  p_r, p_nxt, q_r, q_nxt;
  logic [LW-1:0]  c_r, c_nxt;
  logic           chg_r, chg_nxt, allm_r, allm_nxt, res_r, res_nxt;
  logic           out_valid_r, out_sync_r;

  logic [CW-1:0]  ns;
  logic [LW-1:0]  nl;
  logic [TW-1:0]  tx, ty;
  logic           pm_rd;
  logic [PAW-1:0] pm_raddr, pm_waddr;
  logic           pm_we, pm_wdata;
  logic           in_acc, in_wr;
  logic [TAW-1:0] in_waddr, ta_addr, tb_addr;
  logic           pair_last;
  logic [SW-1:0]  adv_p, adv_q, lo, hi;

  assign ns = CW'((int'(sc_r) > MAX_STATES) ? MAX_STATES : int'(sc_r));
  assign nl = LW'((int'(lc_r) > MAX_LETTERS) ? MAX_LETTERS : int'(lc_r));

  // configuration, taken any time
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= SCW'(SC_RST);
      lc_r <= LCW'(LC_RST);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STATE_COUNT) sc_r <= cfg_wdata[SCW-1:0];
      else                              lc_r <= cfg_wdata[LCW-1:0];
    end
  end

  // table load
  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_wr    = in_acc && (int'(in_from_state) < MAX_STATES)
                    && (int'(in_letter) < MAX_LETTERS);
  assign in_waddr = TAW'(int'(in_from_state) * MAX_LETTERS + int'(in_letter));
  assign ta_addr  = TAW'(int'(p_r) * MAX_LETTERS + int'(c_r));
  assign tb_addr  = TAW'(int'(q_r) * MAX_LETTERS + int'(c_r));

  spc_table #(.DEPTH(TDEPTH), .AW(TAW)) u_table (
    .clk(clk), .we(in_wr), .waddr(in_waddr), .wdata(in_next_state),
    .raddr_a(ta_addr), .raddr_b(tb_addr), .rdata_a(tx), .rdata_b(ty)
  );

  // ordered target pair
  assign lo = (tx < ty) ? SW'(tx) : SW'(ty);
  assign hi = (tx < ty) ? SW'(ty) : SW'(tx);
  assign pm_raddr = (st_r == ST_PM) ? PAW'(int'(p_r) * MAX_STATES + int'(q_r))
                                    : PAW'(int'(lo) * MAX_STATES + int'(hi));

  spc_pair #(.DEPTH(PDEPTH), .AW(PAW)) u_pair (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rd)
  );
  assign pm_waddr = PAW'(int'(p_r) * MAX_STATES + int'(q_r));

  // next pair in sweep order
  assign pair_last = (int'(q_r) + 1 >= int'(ns)) && (int'(p_r) + 2 >= int'(ns));
  always_comb begin
    if (int'(q_r) + 1 < int'(ns)) begin
      adv_p = p_r;
      adv_q = SW'(int'(q_r) + 1);
    end else begin
      adv_p = SW'(int'(p_r) + 1);
      adv_q = SW'(int'(p_r) + 2);
    end
  end

  always_comb begin
    logic merge, miss, look, fin;
    st_nxt   = st_r;
    p_nxt    = p_r;
    q_nxt    = q_r;
    c_nxt    = c_r;
    chg_nxt  = chg_r;
    allm_nxt = allm_r;
    res_nxt  = res_r;
    pm_we    = 1'b0;
    pm_wdata = 1'b0;
    merge    = 1'b0;
    miss     = 1'b0;
    look     = 1'b0;
    fin      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc && in_last) begin
          p_nxt = '0;
          q_nxt = SW'(1);
          if (int'(ns) < 2) begin
            res_nxt = 1'b1;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        pm_we = 1'b1;
        if (pair_last) begin
          p_nxt    = '0;
          q_nxt    = SW'(1);
          c_nxt    = '0;
          chg_nxt  = 1'b0;
          allm_nxt = 1'b1;
          st_nxt   = ST_PM;
        end else begin
          p_nxt = adv_p;
          q_nxt = adv_q;
        end
      end
      ST_PM: begin
        c_nxt  = '0;
        st_nxt = ST_CHK;
      end
      ST_CHK, ST_TEV: begin
        if (st_r == ST_CHK && (pm_rd || nl == '0)) begin
          if (!pm_rd) allm_nxt = 1'b0;
          fin = 1'b1;
        end else if (tx == ty) begin
          merge = 1'b1;
        end else if (int'(tx) >= int'(ns) || int'(ty) >= int'(ns)) begin
          miss = 1'b1;
        end else begin
          look = 1'b1;
        end
      end
      ST_LOOK: begin
        if (pm_rd) merge = 1'b1;
        else       miss  = 1'b1;
      end
      ST_TRD: begin
        st_nxt = ST_TEV;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase

    if (look) st_nxt = ST_LOOK;
    if (merge) begin
      pm_we    = 1'b1;
      pm_wdata = 1'b1;
      chg_nxt  = 1'b1;
      fin      = 1'b1;
    end
    if (miss) begin
      if (int'(c_r) + 1 < int'(nl)) begin
        c_nxt  = LW'(int'(c_r) + 1);
        st_nxt = ST_TRD;
      end else begin
        allm_nxt = 1'b0;
        fin      = 1'b1;
      end
    end
    if (fin) begin
      c_nxt = '0;
      if (!pair_last) begin
        p_nxt  = adv_p;
        q_nxt  = adv_q;
        st_nxt = ST_PM;
      end else if (chg_nxt) begin
        p_nxt    = '0;
        q_nxt    = SW'(1);
        chg_nxt  = 1'b0;
        allm_nxt = 1'b1;
        st_nxt   = ST_PM;
      end else begin
        res_nxt = allm_nxt;
        st_nxt  = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    c_r    <= c_nxt;
    chg_r  <= chg_nxt;
    allm_r <= allm_nxt;
    res_r  <= res_nxt;
    if (st_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_sync_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_synchronizing = out_sync_r;
endmodule

// File: dv/synchronizing_pair_check_tb.sv
// Testbench for synchronizing_pair_check: loads random and directed automata,
// predicts the synchronizing verdict in a scoreboard class and checks each result.
// Depends on spc_pkg and the synchronizing_pair_check RTL.
module synchronizing_pair_check_tb;
  import spc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Verdict predictor: keeps its own copy of the transition table and the
  // register settings, and a queue of verdicts still owed by the block.
  class sync_verdict_board;
    logic [3:0] trans [MAX_STATES_DEF*MAX_LETTERS_DEF];
    int unsigned n_states, n_letters;
    bit verdicts [$];
    int errors;

    function void reset_state();
      foreach (trans[i]) trans[i] = '0;
      n_states = SC_RST;
      n_letters = LC_RST;
      verdicts.delete();
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == CFG_STATE_COUNT) n_states = v[4:0];
      else n_letters = v[2:0];
    endfunction

    // Fixed-point sweep over all pairs, same ordering as the block.
    function bit decide();
      bit merged [MAX_STATES_DEF][MAX_STATES_DEF];
      int unsigned ns, nl, x, y;
      bit changed;
      ns = (n_states > MAX_STATES_DEF) ? MAX_STATES_DEF : n_states;
      nl = (n_letters > MAX_LETTERS_DEF) ? MAX_LETTERS_DEF : n_letters;
      foreach (merged[i, j]) merged[i][j] = 0;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int p = 0; p < ns; p++)
          for (int q = p + 1; q < ns; q++) begin
            if (merged[p][q]) continue;
            for (int c = 0; c < nl; c++) begin
              x = trans[p*MAX_LETTERS_DEF + c];
              y = trans[q*MAX_LETTERS_DEF + c];
              if (x == y || (x < ns && y < ns && merged[x][y])) begin
                merged[p][q] = 1;
                merged[q][p] = 1;
                changed = 1;
                break;
              end
            end
          end
      end
      for (int p = 0; p < ns; p++)
        for (int q = p + 1; q < ns; q++)
          if (!merged[p][q]) return 0;
      return 1;
    endfunction

    function void note_entry(logic [3:0] fs, logic [1:0] lt, logic [3:0] nx, logic lst);
      trans[fs*MAX_LETTERS_DEF + lt] = nx;
      if (lst) verdicts.push_back(decide());
    endfunction

    function void check_verdict(logic got);
      bit exp_v;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result, actual synchronizing=%0b", $realtime, got);
        errors++;
        return;
      end
      exp_v = verdicts.pop_front();
      if (got !== exp_v) begin
        $display("%0t: synchronizing mismatch, expected %0b actual %0b",
                 $realtime, exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_stall, in_last;
  logic [3:0] in_from_state, in_next_state;
  logic [1:0] in_letter;
  logic       out_valid, out_stall, out_synchronizing;
  logic       cfg_valid, cfg_ready, cfg_index;
  logic [7:0] cfg_wdata;

  sync_verdict_board board;
  int send_idle_pct, recv_stall_pct;  // idling odds for the current phase
  int verdicts_seen;

  synchronizing_pair_check dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard limit. The slowest legal check is one for 16 states and 4 letters
  // over a handful of sweeps.
  initial begin
    #40_000_000;
    $display("synchronizing_pair_check test failed");
    $finish;
  end

  // Result side: random stall, check on every accepted transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        board.check_verdict(out_synchronizing);
        verdicts_seen++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One input transaction; valid stays up until accepted.
  task automatic send_entry(logic [3:0] fs, logic [1:0] lt, logic [3:0] nx, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_from_state <= fs;
    in_letter <= lt;
    in_next_state <= nx;
    in_last <= lst;
    do @(posedge clk); while (in_stall);
    board.note_entry(fs, lt, nx, lst);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Full table load for all states/letters in use, then a check. Targets
  // mostly stay in range; some go past state_count to hit that case.
  task automatic load_automaton(int ns, int nl, int mode);
    int lim_s, lim_l, last_s, last_l;
    logic [3:0] nx;
    lim_s = (board.n_states > 16) ? 16 : board.n_states;
    lim_l = (board.n_letters > 4) ? 4 : board.n_letters;
    last_s = lim_s - 1;
    last_l = (lim_l == 0) ? 0 : lim_l - 1;
    for (int s = 0; s < lim_s; s++)
      for (int c = 0; c < lim_l; c++) begin
        case (mode)
          0: nx = 4'($urandom_range(lim_s - 1));
          1: nx = 4'((c == 0) ? ((s + 1) % lim_s) : ((s == 0) ? 1 : s)); // near-Cerny
          2: nx = 4'(s);                                                 // identity
          default: nx = 4'($urandom_range(15));
        endcase
        send_entry(4'(s), 2'(c), nx, (s == last_s && c == last_l));
      end
    if (lim_l == 0)
      send_entry(4'($urandom_range(15)), 2'($urandom_range(3)), 4'($urandom_range(15)), 1'b1);
  endtask

  initial begin
    int items;
    board = new();
    board.reset_state();
    rst_n = 0;
    in_valid = 0; in_from_state = 0; in_letter = 0; in_next_state = 0; in_last = 0;
    out_stall = 0;
    cfg_valid = 0; cfg_index = CFG_STATE_COUNT; cfg_wdata = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    verdicts_seen = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: default config (16 states, 2 letters), extremes of fields.
    load_automaton(16, 2, 2);
    drain();
    load_automaton(16, 2, 1);
    drain();
    write_reg(CFG_STATE_COUNT, 8'd2);
    write_reg(CFG_LETTER_COUNT, 8'd1);
    send_entry(0, 0, 1, 0);
    send_entry(1, 0, 1, 1);          // both to state 1: merges
    send_entry(15, 3, 15, 0);        // outside used range, still loads
    send_entry(1, 0, 0, 1);          // swap: not synchronizing
    drain();
    write_reg(CFG_LETTER_COUNT, 8'd0);   // zero letters
    send_entry(0, 0, 0, 1);
    drain();
    write_reg(CFG_STATE_COUNT, 8'd1);    // fewer than two states
    write_reg(CFG_LETTER_COUNT, 8'd7);   // saturates at 4
    send_entry(0, 0, 0, 1);
    drain();
    write_reg(CFG_STATE_COUNT, 8'd31);   // saturates at 16
    write_reg(CFG_LETTER_COUNT, 8'd4);
    load_automaton(16, 4, 3);
    drain();

    // Random phases over idling profiles and register settings.
    items = 0;
    for (int ph = 0; items < 1200; ph++) begin
      case (ph % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(CFG_STATE_COUNT,
                ($urandom_range(3) == 0) ? 8'd16 : 8'($urandom_range(2, 6)));
      write_reg(CFG_LETTER_COUNT, 8'($urandom_range(1, 4)));
      for (int k = 0; k < 6; k++) begin
        load_automaton(0, 0, ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3));
        // occasional overwrite of one entry in use, then recheck
        if ($urandom_range(3) == 0) begin
          send_entry(4'($urandom_range(board.n_states > 16 ? 15 : board.n_states - 1)),
                     2'($urandom_range(board.n_letters > 4 ? 3 : board.n_letters - 1)),
                     4'($urandom_range(15)), 1'b1);
          items++;
        end
        items += board.n_states * board.n_letters;
      end
      drain();
    end

    drain();
    if (board.errors == 0)
      $display("synchronizing_pair_check test passed");
    else
      $display("synchronizing_pair_check test failed");
    $finish;
  end
endmodule

// File: filelist.f
rtl/spc_pkg.sv
rtl/spc_table.sv
rtl/spc_pair.sv
rtl/synchronizing_pair_check.sv
dv/synchronizing_pair_check_tb.sv
